// ----- rtl/vn_pkg.sv -----
// Shared constants for the vector normalization block.
// No dependencies; used by the interfaces, the iteration stage and the top level.
package vn_pkg;

  // Default component width and fraction bits of the fixed-point format.
  localparam int COMPONENT_WIDTH_DEF = 24;
  localparam int FRACTION_BITS_DEF   = 16;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ZERO = 1'b1;

endpackage

// ----- rtl/vn_vec_if.sv -----
// Input and output stream interfaces of the vector normalization block.
// Depends on vn_pkg for the default widths.
interface vn_vec_if #(
  parameter int CW = vn_pkg::COMPONENT_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] vec_x;
  logic [CW-1:0] vec_y;
  logic [CW-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface vn_unit_if #(
  parameter int OW = vn_pkg::FRACTION_BITS_DEF + 2
);
  logic          valid;
  logic          ready;
  logic [OW-1:0] unit_x;
  logic [OW-1:0] unit_y;
  logic [OW-1:0] unit_z;
  logic          status;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output status, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input status, output ready);
endinterface

// ----- rtl/vec3_normalize_unit.sv -----
// Top level of the three-component vector normalization block.
// Depends on vn_pkg, vn_vec_if, vn_unit_if and vn_iter_stage.
//
// Usage: vectors enter on in_if (vec_x, vec_y, vec_z, signed fixed point with
// FRACTION_BITS fraction bits) and unit vectors leave on out_if (unit_x,
// unit_y, unit_z in signed Q1.FRACTION_BITS, truncated toward zero, plus
// status). A transfer happens on a rising edge with valid and ready high.
// A zero vector returns zero components with status set.
// Pipeline: magnitude, squares, sum, one stage per quotient bit
// (FRACTION_BITS + 1 stages, each a shift-add and compare of the running
// square), and an output register. One vector is taken per cycle when the
// output is drained. Each stage has its own valid bit and advances when it
// is empty or the stage after it advances, so bubbles close up while the
// receiver stalls and in_if.ready stays high until the whole pipeline is
// full. A stalled result holds on out_if. Reset empties all stages; no
// result is pending after reset.
module vec3_normalize_unit #(
  parameter int COMPONENT_WIDTH = vn_pkg::COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = vn_pkg::FRACTION_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  vn_vec_if.sink    in_if,
  vn_unit_if.source out_if
);
  import vn_pkg::*;

  localparam int CW  = COMPONENT_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int SQW = 2 * CW;
  localparam int SW  = 2 * CW + 2;
  localparam int QW  = FB + 1;
  localparam int OW  = FB + 2;
  localparam int W   = SW + 2 * FB + 3;
  localparam int NB  = FB + 1;
  localparam int NS  = NB + 4;
  localparam int FIRST_BIT = 3;

  // Stage valid bits and advance chain.
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_if.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_if.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage A: sign and magnitude of each component.
  logic [2:0][CW-1:0] comp;
  logic [2:0][CW-1:0] mag_a_q;
  logic [2:0]         neg_a_q;

  assign comp[0] = in_if.vec_x;
  assign comp[1] = in_if.vec_y;
  assign comp[2] = in_if.vec_z;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        neg_a_q[l] <= comp[l][CW-1];
        mag_a_q[l] <= comp[l][CW-1] ? (~comp[l] + CW'(1)) : comp[l];
      end
    end
  end

  // Stage B: squares of the magnitudes.
  logic [2:0][SQW-1:0] sq_b_q;
  logic [2:0]          neg_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        sq_b_q[l] <= SQW'(mag_a_q[l]) * SQW'(mag_a_q[l]);
      end
      neg_b_q <= neg_a_q;
    end
  end

  // Stage C: squared length and the scaled squares to compare against.
  logic [SW-1:0]       sum_c;
  logic [SW-1:0]       s_c_q;
  logic [2:0][W-1:0]   r_c_q;
  logic [2:0]          neg_c_q;
  logic                zero_c_q;

  assign sum_c = SW'(sq_b_q[0]) + SW'(sq_b_q[1]) + SW'(sq_b_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s_c_q    <= sum_c;
      zero_c_q <= (sum_c == '0);
      neg_c_q  <= neg_b_q;
      for (int l = 0; l < 3; l++) begin
        r_c_q[l] <= W'(sq_b_q[l]) << (2 * FB);
      end
    end
  end

  // Quotient-bit stages, most significant bit first.
  logic [SW-1:0]        ch_s    [NB+1];
  logic [2:0][W-1:0]    ch_r    [NB+1];
  logic [2:0][W-1:0]    ch_p    [NB+1];
  logic [2:0][W-1:0]    ch_t    [NB+1];
  logic [2:0][QW-1:0]   ch_q    [NB+1];
  logic [2:0]           ch_neg  [NB+1];
  logic                 ch_zero [NB+1];

  assign ch_s[0]    = s_c_q;
  assign ch_r[0]    = r_c_q;
  assign ch_p[0]    = '0;
  assign ch_t[0]    = '0;
  assign ch_q[0]    = '0;
  assign ch_neg[0]  = neg_c_q;
  assign ch_zero[0] = zero_c_q;

  for (genvar i = 0; i < NB; i++) begin : g_bit
    vn_iter_stage #(
      .SW  (SW),
      .W   (W),
      .QW  (QW),
      .BIT (FB - i)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (rdy[FIRST_BIT + i]),
      .s_i    (ch_s[i]),
      .r_i    (ch_r[i]),
      .p_i    (ch_p[i]),
      .t_i    (ch_t[i]),
      .q_i    (ch_q[i]),
      .neg_i  (ch_neg[i]),
      .zero_i (ch_zero[i]),
      .s_o    (ch_s[i+1]),
      .r_o    (ch_r[i+1]),
      .p_o    (ch_p[i+1]),
      .t_o    (ch_t[i+1]),
      .q_o    (ch_q[i+1]),
      .neg_o  (ch_neg[i+1]),
      .zero_o (ch_zero[i+1])
    );
  end

  // Output stage: restore the sign, force a zero vector to zero.
  logic [2:0][OW-1:0] unit_q;
  logic               status_q;

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      for (int l = 0; l < 3; l++) begin
        if (ch_zero[NB]) begin
          unit_q[l] <= '0;
        end else if (ch_neg[NB][l]) begin
          unit_q[l] <= ~OW'(ch_q[NB][l]) + OW'(1);
        end else begin
          unit_q[l] <= OW'(ch_q[NB][l]);
        end
      end
      status_q <= ch_zero[NB] ? STATUS_ZERO : STATUS_OK;
    end
  end

  assign out_if.valid  = v_q[NS-1];
  assign out_if.unit_x = unit_q[0];
  assign out_if.unit_y = unit_q[1];
  assign out_if.unit_z = unit_q[2];
  assign out_if.status = status_q;

`ifndef SYNTHESIS
  localparam logic signed [OW-1:0] ONE_P = OW'(1) << FB;
  localparam logic signed [OW-1:0] ONE_N = -(OW'(1) << FB);

  // A zero-length result carries zero components.
  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == STATUS_ZERO |->
      out_if.unit_x == '0 && out_if.unit_y == '0 && out_if.unit_z == '0)
    else $error("zero-length result with nonzero components");

  // A nonzero vector has at least one nonzero unit component.
  a_nonzero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status == STATUS_OK |->
      out_if.unit_x != '0 || out_if.unit_y != '0 || out_if.unit_z != '0)
    else $error("nonzero vector gave an all-zero unit vector");

  // Every unit component stays within plus or minus one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |->
      $signed(out_if.unit_x) <= ONE_P && $signed(out_if.unit_x) >= ONE_N &&
      $signed(out_if.unit_y) <= ONE_P && $signed(out_if.unit_y) >= ONE_N &&
      $signed(out_if.unit_z) <= ONE_P && $signed(out_if.unit_z) >= ONE_N)
    else $error("unit component out of range");

  // An empty first stage always takes a new vector.
  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_if.ready)
    else $error("input stalled with an empty first stage");
`endif

endmodule

// ----- rtl/vn_iter_stage.sv -----
// One quotient-bit stage of the normalization pipeline, for all three lanes.
// Depends on vn_pkg; instantiated by vec3_normalize_unit.
module vn_iter_stage #(
  parameter int SW  = 50,
  parameter int W   = 85,
  parameter int QW  = 17,
  parameter int BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SW-1:0]        s_i,
  input  logic [2:0][W-1:0]    r_i,
  input  logic [2:0][W-1:0]    p_i,
  input  logic [2:0][W-1:0]    t_i,
  input  logic [2:0][QW-1:0]   q_i,
  input  logic [2:0]           neg_i,
  input  logic                 zero_i,
  output logic [SW-1:0]        s_o,
  output logic [2:0][W-1:0]    r_o,
  output logic [2:0][W-1:0]    p_o,
  output logic [2:0][W-1:0]    t_o,
  output logic [2:0][QW-1:0]   q_o,
  output logic [2:0]           neg_o,
  output logic                 zero_o
);
  import vn_pkg::*;

  logic [W-1:0]         s_wide;
  logic [2:0][W-1:0]    cand_p;
  logic [2:0]           take;
  logic [2:0][W-1:0]    p_d, t_d;
  logic [2:0][QW-1:0]   q_d;

  assign s_wide = W'(s_i);

  // With P = q*q*S and T = q*S, setting this bit gives
  // (q + 2^b)^2 * S = P + 2^(b+1) * T + 2^(2b) * S.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cand_p[l] = p_i[l] + (t_i[l] << (BIT + 1)) + (s_wide << (2 * BIT));
      take[l]   = (cand_p[l] <= r_i[l]);
      p_d[l]    = take[l] ? cand_p[l] : p_i[l];
      t_d[l]    = take[l] ? (t_i[l] + (s_wide << BIT)) : t_i[l];
      q_d[l]    = take[l] ? (q_i[l] | (QW'(1) << BIT)) : q_i[l];
    end
  end

  // Payload register, loaded when the stage advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o    <= s_i;
      r_o    <= r_i;
      p_o    <= p_d;
      t_o    <= t_d;
      q_o    <= q_d;
      neg_o  <= neg_i;
      zero_o <= zero_i;
    end
  end

endmodule

// ----- dv/tb_vec3_normalize_unit.sv -----
// Self-checking testbench for vec3_normalize_unit with the default Q8.16 inputs.
// Depends on vn_pkg, vn_vec_if and vn_unit_if; an exact integer predictor computes
// every unit vector and a checker compares each output transfer against it.
module tb_vec3_normalize_unit;
  import vn_pkg::*;

  localparam int CW        = COMPONENT_WIDTH_DEF;
  localparam int FB        = FRACTION_BITS_DEF;
  localparam int OW        = FB + 2;
  localparam int LATENCY   = FB + 5;
  localparam int MAX_CYCLE = 400000;

  typedef logic [CW-1:0] comp_t;
  typedef struct packed {
    logic [OW-1:0] ux;
    logic [OW-1:0] uy;
    logic [OW-1:0] uz;
    logic          status;
  } unit_vec_t;

  logic clk_i;
  logic rst_ni;

  vn_vec_if  #(.CW(CW)) in_if ();
  vn_unit_if #(.OW(OW)) out_if ();

  vec3_normalize_unit #(
    .COMPONENT_WIDTH(CW),
    .FRACTION_BITS  (FB)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  unit_vec_t expected_units[$];
  int        mismatch_count;
  int        result_count;
  int        vector_count;
  int        zero_count;
  int        cycle_count;
  bit        send_idle_en;
  bit        recv_idle_en;
  int        recv_hold_cycles;

  // Clock generation.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Global cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One normalized component: largest q with q*q*S <= c*c*2^(2*FB), then the sign.
  function automatic logic [OW-1:0] unit_component(logic [CW:0] mag, logic neg,
                                                   logic [127:0] sum_sq);
    logic [127:0] bound;
    logic [127:0] cand;
    logic [127:0] q;
    bound = (128'(mag) * 128'(mag)) << (2 * FB);
    q = '0;
    for (int b = FB; b >= 0; b--) begin
      cand = q | (128'(1) << b);
      if (cand * cand * sum_sq <= bound) q = cand;
    end
    return neg ? OW'(-q) : OW'(q);
  endfunction

  // Unit vector of one input vector, with the zero-length case flagged.
  function automatic unit_vec_t normalize_vec(comp_t x, comp_t y, comp_t z);
    unit_vec_t    r;
    logic [CW:0]  mx, my, mz;
    logic [127:0] sum_sq;
    mx = x[CW-1] ? (CW+1)'(-$signed({x[CW-1], x})) : {1'b0, x};
    my = y[CW-1] ? (CW+1)'(-$signed({y[CW-1], y})) : {1'b0, y};
    mz = z[CW-1] ? (CW+1)'(-$signed({z[CW-1], z})) : {1'b0, z};
    sum_sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
    if (sum_sq == 0) begin
      r.ux = '0;
      r.uy = '0;
      r.uz = '0;
      r.status = STATUS_ZERO;
    end else begin
      r.ux = unit_component(mx, x[CW-1], sum_sq);
      r.uy = unit_component(my, y[CW-1], sum_sq);
      r.uz = unit_component(mz, z[CW-1], sum_sq);
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  // Offer one vector, after a random gap when sender idling is on, and wait for its transfer.
  task automatic send_vec(comp_t x, comp_t y, comp_t z);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.vec_x <= x;
    in_if.vec_y <= y;
    in_if.vec_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    expected_units.push_back(normalize_vec(x, y, z));
    vector_count++;
    if (x == 0 && y == 0 && z == 0) zero_count++;
  endtask

  // Lower valid and wait until every expected result has come.
  task automatic drain;
    in_if.valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
  endtask

  // Random component: full range, small magnitude or an extreme value.
  function automatic comp_t rand_comp();
    int unsigned sel;
    int unsigned sh;
    sel = $urandom_range(0, 9);
    sh = $urandom_range(0, CW - 1);
    case (sel)
      0, 1, 2, 3: return comp_t'($urandom);
      4, 5:       return comp_t'($signed(comp_t'($urandom)) >>> sh);
      6:          return '0;
      7:          return {1'b1, {(CW-1){1'b0}}};
      8:          return {1'b0, {(CW-1){1'b1}}};
      default:    return comp_t'($urandom_range(0, 3)) - comp_t'(2);
    endcase
  endfunction

  // Receiver: random stalls per result when receiver idling is on, plus long holds on request.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (recv_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (recv_hold_cycles) @(posedge clk_i);
        recv_hold_cycles = 0;
      end
      stall = recv_idle_en ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Compare every output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    unit_vec_t exp_u;
    unit_vec_t got_u;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_u = '{out_if.unit_x, out_if.unit_y, out_if.unit_z, out_if.status};
      result_count++;
      if (expected_units.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result x=%0d y=%0d z=%0d status=%0b",
                   $signed(got_u.ux), $signed(got_u.uy), $signed(got_u.uz),
                   got_u.status);
      end else begin
        exp_u = expected_units.pop_front();
        if (got_u !== exp_u) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected x=%0d y=%0d z=%0d status=%0b, got x=%0d y=%0d z=%0d status=%0b",
                     $signed(exp_u.ux), $signed(exp_u.uy), $signed(exp_u.uz), exp_u.status,
                     $signed(got_u.ux), $signed(got_u.uy), $signed(got_u.uz), got_u.status);
        end
      end
    end
  end

  // Directed vectors: zero, axes, extremes and simple diagonals.
  task automatic test_directed;
    comp_t vmax;
    comp_t vmin;
    vmax = {1'b0, {(CW-1){1'b1}}};
    vmin = {1'b1, {(CW-1){1'b0}}};
    send_vec('0, '0, '0);
    send_vec(vmax, '0, '0);
    send_vec('0, vmax, '0);
    send_vec('0, '0, vmax);
    send_vec(vmin, '0, '0);
    send_vec('0, vmin, '0);
    send_vec('0, '0, vmin);
    send_vec(comp_t'(1), '0, '0);
    send_vec('0, '0, '1);
    send_vec(comp_t'(1), comp_t'(1), comp_t'(1));
    send_vec('1, '1, '1);
    send_vec(vmax, vmax, vmax);
    send_vec(vmin, vmin, vmin);
    send_vec(vmin, vmax, comp_t'(1));
    send_vec(comp_t'(3 << FB), comp_t'(4 << FB), '0);
    send_vec(comp_t'(-(2 << FB)), comp_t'(1 << FB), comp_t'(2 << FB));
    send_vec(comp_t'(1), vmax, '0);
    send_vec(vmin, '1, '0);
    send_vec('0, '0, '0);
    drain();
  endtask

  // Random vectors, with idling on both sides set by idle and switched back on afterwards.
  task automatic test_random(int count, bit idle);
    send_idle_en = idle;
    recv_idle_en = idle;
    repeat (count) send_vec(rand_comp(), rand_comp(), rand_comp());
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // Long receiver hold while the sender keeps offering back to back.
  task automatic test_backpressure;
    send_idle_en = 1'b0;
    recv_hold_cycles = 120;
    repeat (80) send_vec(rand_comp(), rand_comp(), rand_comp());
    send_idle_en = 1'b1;
  endtask

  // Sender pause until the pipeline has fully drained, then resume.
  task automatic test_drain_pause;
    drain();
    repeat (50) send_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.vec_x <= '0;
    in_if.vec_y <= '0;
    in_if.vec_z <= '0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    recv_hold_cycles = 0;
    mismatch_count = 0;
    result_count = 0;
    vector_count = 0;
    zero_count = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(700, 1'b1);
    test_backpressure();
    test_random(300, 1'b0);
    test_drain_pause();
    test_random(500, 1'b1);

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d vectors (%0d zero-length), checked %0d unit vectors",
             vector_count, zero_count, result_count);
    $display("Covered axes, extremes, random idling, long output hold and full drain");
    if (mismatch_count == 0 && expected_units.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_units.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
